@@ src/kfst_pkg.sv @@
// Shared types and codes for the keyed flag table.
// Used by kfst_ram, kfst_ctrl and keyed_flag_table_swap_remove_top; no dependencies.
package kfst_pkg;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_QUERY     = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [15:0] flags;
  } cmd_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] status;
    logic [4:0] entry_count;
    logic [4:0] active_count;
  } result_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] flags;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MOVE_RD,
    S_MOVE_WR,
    S_COUNT,
    S_DONE
  } state_t;

endpackage

@@ src/kfst_ram.sv @@
// Entry store of the keyed flag table: one write port, one registered read port.
// Depends on kfst_pkg for entry_t.
module kfst_ram
  import kfst_pkg::*;
#(
  parameter int TABLE_DEPTH,
  parameter int AW
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/kfst_ctrl.sv @@
// Sequencer and shared compare unit of the keyed flag table: search, move, count.
// Depends on kfst_pkg; drives the ports of kfst_ram.
module kfst_ctrl
  import kfst_pkg::*;
#(
  parameter int TABLE_DEPTH,
  parameter int AW,
  parameter int CW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cmd_t          cmd,
  input  logic [15:0]   mask,
  output logic          busy,
  output logic          done,
  output result_t       result,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  state_t        state, state_next;
  cmd_t          op;
  logic [CW-1:0] used;
  logic [CW-1:0] idx;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] act_cnt;
  logic [CW-1:0] slot_r;
  logic [CW-1:0] last;
  logic [2:0]    status_r;
  logic          rd_pend;

  logic hit, is_act, issue, scan_end, full;

  // Shared compare unit: key match and active test on the word just read
  assign hit      = rd_pend && (mem_rdata.key == op.key);
  assign is_act   = rd_pend && ((mem_rdata.flags & mask) != 16'd0);
  assign issue    = idx < used;
  assign scan_end = !issue && !rd_pend;
  assign full     = used == CW'(TABLE_DEPTH);
  assign last     = used - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd.kind == KIND_ADD) begin
            state_next = full ? S_COUNT : S_SEARCH;
          end else if (cmd.kind == KIND_REMOVE) begin
            state_next = S_SEARCH;
          end else begin
            state_next = S_COUNT;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_next = (op.kind == KIND_REMOVE) ? S_MOVE_RD : S_COUNT;
        end else if (scan_end) begin
          state_next = S_COUNT;
        end
      end
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: state_next = S_COUNT;
      S_COUNT: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = '{key: op.key, flags: op.flags};
    mem_raddr = idx[AW-1:0];
    unique case (state)
      S_SEARCH: begin
        if (hit && op.kind == KIND_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx[AW-1:0];
        end else if (!hit && scan_end && op.kind == KIND_ADD) begin
          mem_we    = 1'b1;
          mem_waddr = used[AW-1:0];
        end
      end
      S_MOVE_RD: mem_raddr = last[AW-1:0];
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          act_cnt <= '0;
          if (start) begin
            op     <= cmd;
            slot_r <= '0;
            if (cmd.kind == KIND_ADD) begin
              status_r <= ST_FULL;
            end else if (cmd.kind == KIND_REMOVE) begin
              status_r <= ST_NOT_FOUND;
            end else begin
              status_r <= ST_QUERY;
            end
          end
        end
        S_SEARCH: begin
          rd_idx <= idx;
          if (hit) begin
            pos      <= rd_idx;
            slot_r   <= rd_idx;
            status_r <= (op.kind == KIND_REMOVE) ? ST_REMOVED : ST_UPDATED;
            idx      <= '0;
            rd_pend  <= 1'b0;
          end else if (scan_end) begin
            if (op.kind == KIND_ADD) begin
              slot_r   <= used;
              used     <= used + 1'b1;
              status_r <= ST_INSERTED;
            end
            idx     <= '0;
            rd_pend <= 1'b0;
          end else begin
            // Advance the read pointer while entries remain
            rd_pend <= issue;
            if (issue) begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_MOVE_RD: ;
        S_MOVE_WR: begin
          used    <= last;
          idx     <= '0;
          rd_pend <= 1'b0;
        end
        S_COUNT: begin
          rd_pend <= issue;
          rd_idx  <= idx;
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (is_act) begin
            act_cnt <= act_cnt + 1'b1;
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy                = state != S_IDLE;
    done                = state == S_DONE;
    result.slot         = 4'(slot_r);
    result.status       = status_r;
    result.entry_count  = 5'(used);
    result.active_count = 5'(act_cnt);
  end

endmodule

@@ src/keyed_flag_table_swap_remove_top.sv @@
// Top level of the keyed flag table with swap-on-remove.
// Depends on kfst_pkg, kfst_ram and kfst_ctrl.
//
// Packed table of up to TABLE_DEPTH (key, flags) entries. Pulse start with a
// command while busy is low; the item is taken at that edge and busy stays high
// until the result has been shown. The result appears on result for exactly one
// cycle with done high; it cannot be held off, so capture it on that cycle. The
// single read port of the entry store is walked one entry per cycle. An add or
// remove first searches for the key: an add that hits updates the entry in
// place and one that misses appends it, and a remove that hits moves the last
// entry into the freed slot. Then every item counts the active entries before
// its result is shown; a query or a rejected add goes straight to the count.
// The table starts empty after reset; no clearing pass is run, since only data
// read from slots below the fill count is ever used. Write active_mask via
// cfg_we and cfg_wdata only while busy is low.
module keyed_flag_table_swap_remove_top
  import kfst_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output result_t     result
);

  // Slot address and fill-count widths
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [15:0]   active_mask;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  // Hold the active mask; reset value selects the two lowest flag bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active_mask <= 16'h0003;
    end else if (cfg_we) begin
      active_mask <= cfg_wdata;
    end
  end

  kfst_ram #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Sequence search, move and count over the store
  kfst_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .mask     (active_mask),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // A result only ever follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result shown without an item in progress");

  // A rejected add reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.entry_count == 5'(TABLE_DEPTH))
    else $error("full rejection with table not full");

  // Active entries never outnumber used entries; checked only for TABLE_DEPTH up to 16
  a_active_le_used: assert property (@(posedge clk) disable iff (rst)
    done |-> (TABLE_DEPTH > 16) || (result.active_count <= result.entry_count))
    else $error("active count exceeds entry count");
`endif

endmodule
